// ===== sv/button_to_keycode_encoder_assert.svh =====
// Assertion macros shared by the button-to-keycode encoder RTL.
`ifndef BUTTON_TO_KEYCODE_ENCODER_ASSERT_SVH
`define BUTTON_TO_KEYCODE_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define BTK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define BTK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BTK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/btk_pkg.sv =====
// Constants, key maps and the control program of the button-to-keycode encoder.
package btk_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_OUT_W = 6;
    localparam logic [SLOT_IDX_W-1:0] SLOT_LAST = SLOT_IDX_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_OUT_W-1:0] SLOT_NONE = SLOT_OUT_W'(SLOT_COUNT);

    // Event kinds.
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TAP     = 2'd2;
    localparam logic [1:0] KIND_TOGGLE  = 2'd3;

    localparam logic [7:0] KEY_1 = 8'd30;
    localparam logic [7:0] KEY_2 = 8'd31;

    // Port numbers.
    localparam logic [1:0] PORT_B = 2'd0;
    localparam logic [1:0] PORT_D = 2'd1;
    localparam logic [1:0] PORT_F = 2'd2;

    // Presses of these bits make no event; releases still do.
    localparam logic [2:0][7:0] PRESS_BLOCK = {8'h0C, 8'h40, 8'h00};

    // Usage code tables, element 0 is bit 0.
    localparam logic [7:0][7:0] MAP_B_NORM =
        {8'd14, 8'd4, 8'd22, 8'd20, 8'd79, 8'd80, 8'd81, 8'd82};
    localparam logic [7:0][7:0] MAP_B_ALT =
        {8'd14, 8'd4, 8'd22, 8'd20, 8'd79, 8'd80, 8'd41, 8'd43};
    localparam logic [7:0][7:0] MAP_D =
        {8'd26, 8'd0, 8'd0, 8'd12, 8'd10, 8'd7, 8'd9, 8'd21};
    localparam logic [7:0][7:0] MAP_F =
        {8'd27, 8'd29, 8'd15, 8'd44, 8'd39, 8'd39, 8'd18, 8'd19};

    function automatic logic [7:0] code_lookup(input logic alt, input logic [1:0] port,
                                               input logic [2:0] bit_idx);
        logic [7:0] c;
        case (port)
            PORT_B:  c = alt ? MAP_B_ALT[bit_idx] : MAP_B_NORM[bit_idx];
            PORT_D:  c = MAP_D[bit_idx];
            default: c = MAP_F[bit_idx];
        endcase
        return c;
    endfunction

    // Program steps.
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_CHECK      = 4'd1;
    localparam logic [3:0] ST_WALK       = 4'd2;
    localparam logic [3:0] ST_EMIT       = 4'd3;
    localparam logic [3:0] ST_NEXT       = 4'd4;
    localparam logic [3:0] ST_START      = 4'd5;
    localparam logic [3:0] ST_TOGGLE     = 4'd6;
    localparam logic [3:0] ST_TAP1       = 4'd7;
    localparam logic [3:0] ST_EMIT_TAP1  = 4'd8;
    localparam logic [3:0] ST_TAP2       = 4'd9;
    localparam logic [3:0] ST_EMIT_TAP2  = 4'd10;

    // Jump conditions.
    localparam logic [3:0] C_ALWAYS   = 4'd0;
    localparam logic [3:0] C_IN_VALID = 4'd1;
    localparam logic [3:0] C_PEND     = 4'd2;
    localparam logic [3:0] C_SLOT_END = 4'd3;
    localparam logic [3:0] C_OUT_FREE = 4'd4;
    localparam logic [3:0] C_LAST_POS = 4'd5;
    localparam logic [3:0] C_TOGGLE   = 4'd6;
    localparam logic [3:0] C_START0   = 4'd7;
    localparam logic [3:0] C_START1   = 4'd8;

    // Datapath operations.
    localparam logic [3:0] OP_NONE        = 4'd0;
    localparam logic [3:0] OP_LOAD        = 4'd1;
    localparam logic [3:0] OP_INIT        = 4'd2;
    localparam logic [3:0] OP_SLOT        = 4'd3;
    localparam logic [3:0] OP_EMIT_PORT   = 4'd4;
    localparam logic [3:0] OP_ADVANCE     = 4'd5;
    localparam logic [3:0] OP_EMIT_TOGGLE = 4'd6;
    localparam logic [3:0] OP_EMIT_TAP1   = 4'd7;
    localparam logic [3:0] OP_EMIT_TAP2   = 4'd8;

    typedef struct packed {
        logic [3:0] cond;
        logic [3:0] op;
        logic [3:0] jump_true;
        logic [3:0] jump_false;
    } ucw_t;

    function automatic ucw_t ucw(input logic [3:0] cond, input logic [3:0] op,
                                 input logic [3:0] jt, input logic [3:0] jf);
        ucw_t w;
        w.cond       = cond;
        w.op         = op;
        w.jump_true  = jt;
        w.jump_false = jf;
        return w;
    endfunction

    // The control program, one word per step.
    function automatic ucw_t ucode_rom(input logic [3:0] step);
        ucw_t w;
        unique case (step)
            ST_IDLE:      w = ucw(C_IN_VALID, OP_LOAD,        ST_CHECK,     ST_IDLE);
            ST_CHECK:     w = ucw(C_PEND,     OP_INIT,        ST_WALK,      ST_NEXT);
            ST_WALK:      w = ucw(C_SLOT_END, OP_SLOT,        ST_EMIT,      ST_WALK);
            ST_EMIT:      w = ucw(C_OUT_FREE, OP_EMIT_PORT,   ST_NEXT,      ST_EMIT);
            ST_NEXT:      w = ucw(C_LAST_POS, OP_ADVANCE,     ST_START,     ST_CHECK);
            ST_START:     w = ucw(C_TOGGLE,   OP_NONE,        ST_TOGGLE,    ST_TAP1);
            ST_TOGGLE:    w = ucw(C_OUT_FREE, OP_EMIT_TOGGLE, ST_IDLE,      ST_TOGGLE);
            ST_TAP1:      w = ucw(C_START0,   OP_NONE,        ST_EMIT_TAP1, ST_TAP2);
            ST_EMIT_TAP1: w = ucw(C_OUT_FREE, OP_EMIT_TAP1,   ST_TAP2,      ST_EMIT_TAP1);
            ST_TAP2:      w = ucw(C_START1,   OP_NONE,        ST_EMIT_TAP2, ST_IDLE);
            ST_EMIT_TAP2: w = ucw(C_OUT_FREE, OP_EMIT_TAP2,   ST_IDLE,      ST_EMIT_TAP2);
            default:      w = ucw(C_ALWAYS,   OP_NONE,        ST_IDLE,      ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== sv/button_to_keycode_encoder.sv =====
// Button scan to keyboard usage code event encoder, microcoded sequencer top level.
//
// Usage: each request on the s_ channel is one scan of three 8-bit button
// ports and two start buttons, all active low. The block compares it with the
// previous scan and sends one request on the m_ channel per press or release
// event, then any start button tap or mode toggle; m_tlast marks the final
// event of a scan. A scan without edges produces nothing.
// Sequencing: a short program steps through the 24 port positions, and every
// port event adds a walk over the 32-slot key table (one slot per cycle) plus
// an output step. The next scan is accepted only once the program is back in
// its idle step.
// The result sits in an output register, so the program goes on with the
// next event while it waits to be taken; when the receiver stalls with a
// result still held, the program halts at its next output step.
// Reset (synchronous, aresetn low) empties the key table, sets the previous
// scan to all released, clears alternate mode and drops m_tvalid.
`include "button_to_keycode_encoder_assert.svh"

module button_to_keycode_encoder
    import btk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // port_b_pins[7:0], port_d_pins[15:8], port_f_pins[23:16], start_pins[25:24]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_kind[1:0], key_code[9:2], slot_index[15:10], cleared_count[21:16],
    // alt_mode[22]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic [3:0]            step_reg, step_next;
    ucw_t                  uw;
    logic                  cond_true;

    logic [2:0][7:0]       prev_reg;
    logic [1:0]            prev_start_reg;
    logic [2:0][7:0]       pend_reg;
    logic [2:0][7:0]       press_reg;
    logic [2:0][7:0]       pend_clr;
    logic [1:0]            start_new_reg;
    logic                  alt_reg;
    logic [1:0]            port_reg;
    logic [2:0]            bit_reg;

    logic [7:0]            code_reg;
    logic                  is_press_reg;
    logic [SLOT_IDX_W-1:0] slot_reg;
    logic                  found_reg;
    logic [SLOT_IDX_W-1:0] found_idx_reg;
    logic [SLOT_OUT_W-1:0] clr_cnt_reg;
    logic [7:0]            key_slots_reg [SLOT_COUNT];
    logic [7:0]            slot_val;

    logic                  out_valid_reg;
    logic [1:0]            out_kind_reg;
    logic [7:0]            out_code_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    logic [SLOT_OUT_W-1:0] out_cnt_reg;
    logic                  out_alt_reg;
    logic                  out_last_reg;
    logic                  out_free;
    logic                  out_load;

    logic [2:0][7:0]       scan_cur;
    logic [1:0]            scan_start;

    assign uw         = ucode_rom(step_reg);
    assign out_free   = !out_valid_reg || m_tready;
    assign scan_cur   = s_tdata[23:0];
    assign scan_start = s_tdata[25:24];
    assign slot_val   = key_slots_reg[slot_reg];

    always_comb begin
        pend_clr = pend_reg;
        pend_clr[port_reg][bit_reg] = 1'b0;
    end

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_IN_VALID: cond_true = s_tvalid;
            C_PEND:     cond_true = pend_reg[port_reg][bit_reg];
            C_SLOT_END: cond_true = (slot_reg == SLOT_LAST);
            C_OUT_FREE: cond_true = out_free;
            C_LAST_POS: cond_true = (port_reg == PORT_F) && (bit_reg == 3'd7);
            C_TOGGLE:   cond_true = (start_new_reg == 2'b11);
            C_START0:   cond_true = start_new_reg[0];
            C_START1:   cond_true = start_new_reg[1];
            default:    cond_true = 1'b0;
        endcase
        step_next = cond_true ? uw.jump_true : uw.jump_false;
    end

    assign out_load = out_free && ((uw.op == OP_EMIT_PORT) || (uw.op == OP_EMIT_TOGGLE) ||
                                   (uw.op == OP_EMIT_TAP1) || (uw.op == OP_EMIT_TAP2));

    assign s_tready = (uw.op == OP_LOAD);

    // Sequencer and datapath state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= ST_IDLE;
            prev_reg       <= {3{8'hFF}};
            prev_start_reg <= 2'b11;
            pend_reg       <= '0;
            press_reg      <= '0;
            start_new_reg  <= 2'b00;
            alt_reg        <= 1'b0;
            port_reg       <= PORT_B;
            bit_reg        <= 3'd0;
            slot_reg       <= '0;
            found_reg      <= 1'b0;
            for (int j = 0; j < SLOT_COUNT; j++) begin
                key_slots_reg[j] <= 8'd0;
            end
        end else begin
            step_reg <= step_next;
            unique case (uw.op)
                OP_LOAD: begin
                    if (s_tvalid) begin
                        for (int p = 0; p < 3; p++) begin
                            press_reg[p] <= ~scan_cur[p] & prev_reg[p] & ~PRESS_BLOCK[p];
                            pend_reg[p]  <= (~scan_cur[p] & prev_reg[p] & ~PRESS_BLOCK[p]) |
                                            (scan_cur[p] & ~prev_reg[p]);
                        end
                        start_new_reg  <= ~scan_start & prev_start_reg;
                        prev_reg       <= scan_cur;
                        prev_start_reg <= scan_start;
                        port_reg       <= PORT_B;
                        bit_reg        <= 3'd0;
                    end
                end
                OP_INIT: begin
                    slot_reg  <= '0;
                    found_reg <= 1'b0;
                end
                OP_SLOT: begin
                    if (is_press_reg) begin
                        // First free slot takes the code; a zero code leaves it free.
                        if (!found_reg && (slot_val == 8'd0)) begin
                            key_slots_reg[slot_reg] <= code_reg;
                            found_reg               <= 1'b1;
                        end
                    end else if ((code_reg != 8'd0) && (slot_val == code_reg)) begin
                        key_slots_reg[slot_reg] <= 8'd0;
                    end
                    if (slot_reg != SLOT_LAST) begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                OP_EMIT_PORT: begin
                    if (out_free) begin
                        pend_reg <= pend_clr;
                    end
                end
                OP_ADVANCE: begin
                    if (port_reg == PORT_F) begin
                        port_reg <= PORT_B;
                        bit_reg  <= bit_reg + 3'd1;
                    end else begin
                        port_reg <= port_reg + 2'd1;
                    end
                end
                OP_EMIT_TOGGLE: begin
                    if (out_free) begin
                        alt_reg <= !alt_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Per-event payload registers.
    always_ff @(posedge aclk) begin
        if (uw.op == OP_INIT) begin
            code_reg      <= code_lookup(alt_reg, port_reg, bit_reg);
            is_press_reg  <= press_reg[port_reg][bit_reg];
            clr_cnt_reg   <= '0;
            found_idx_reg <= '0;
        end else if (uw.op == OP_SLOT) begin
            if (is_press_reg) begin
                if (!found_reg && (slot_val == 8'd0)) begin
                    found_idx_reg <= slot_reg;
                end
            end else if ((code_reg != 8'd0) && (slot_val == code_reg)) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            unique case (uw.op)
                OP_EMIT_PORT: begin
                    out_kind_reg <= is_press_reg ? KIND_PRESS : KIND_RELEASE;
                    out_code_reg <= code_reg;
                    out_slot_reg <= found_reg ? SLOT_OUT_W'(found_idx_reg) : SLOT_NONE;
                    out_cnt_reg  <= clr_cnt_reg;
                    out_alt_reg  <= alt_reg;
                    out_last_reg <= (pend_clr == '0) && (start_new_reg == 2'b00);
                end
                OP_EMIT_TOGGLE: begin
                    out_kind_reg <= KIND_TOGGLE;
                    out_code_reg <= 8'd0;
                    out_slot_reg <= SLOT_NONE;
                    out_cnt_reg  <= '0;
                    out_alt_reg  <= !alt_reg;
                    out_last_reg <= 1'b1;
                end
                OP_EMIT_TAP1: begin
                    out_kind_reg <= KIND_TAP;
                    out_code_reg <= KEY_1;
                    out_slot_reg <= SLOT_NONE;
                    out_cnt_reg  <= '0;
                    out_alt_reg  <= alt_reg;
                    out_last_reg <= !start_new_reg[1];
                end
                default: begin
                    out_kind_reg <= KIND_TAP;
                    out_code_reg <= KEY_2;
                    out_slot_reg <= SLOT_NONE;
                    out_cnt_reg  <= '0;
                    out_alt_reg  <= alt_reg;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_alt_reg, out_cnt_reg, out_slot_reg, out_code_reg,
                       out_kind_reg};

    // A new scan is only taken once every port event of the last one is out.
    `BTK_ASSERT_IMP(a_idle_drained, aclk, aresetn, step_reg == ST_IDLE, pend_reg == '0,
                    "new scan taken with port events still pending")
    // An accepted scan always starts the position walk.
    `BTK_ASSERT_NXT(a_accept_check, aclk, aresetn, s_tvalid && s_tready,
                    step_reg == ST_CHECK, "accepted scan did not start the position walk")
    // The slot walk runs over the whole table before the event is sent.
    `BTK_ASSERT_NXT(a_walk_full, aclk, aresetn, (step_reg == ST_WALK) && (slot_reg != SLOT_LAST),
                    step_reg == ST_WALK, "slot walk left early")
    // Only a press reports a slot.
    `BTK_ASSERT_IMP(a_slot_press, aclk, aresetn, m_tvalid && (m_tdata[15:10] != SLOT_NONE),
                    m_tdata[1:0] == KIND_PRESS, "slot reported for an event that is not a press")
    // A mode toggle always closes its scan.
    `BTK_ASSERT_IMP(a_toggle_last, aclk, aresetn, m_tvalid && (m_tdata[1:0] == KIND_TOGGLE),
                    m_tlast, "mode toggle not marked as final event")

endmodule
